// ===== sv/hsvt_pkg.sv =====
// ============================================================================
// hsvt_pkg
// Shared types and constants for the HSV color threshold mask pipeline.
// ============================================================================
`default_nettype none

package hsvt_pkg;

    // Color mode register codes. The unused code selects nothing.
    typedef enum logic [1:0] {
        MODE_YELLOW     = 2'd0,
        MODE_YELLOW_EXP = 2'd1,
        MODE_RED        = 2'd2
    } color_mode_t;

    // Which channel holds the maximum (red wins ties, then green)
    typedef enum logic [1:0] {
        MAX_RED   = 2'd0,
        MAX_GREEN = 2'd1,
        MAX_BLUE  = 2'd2
    } max_sel_t;

    localparam int unsigned CHAN_W = 8;
    localparam int unsigned KP_W   = 11;   // shifted hue numerator, up to 6*255
    localparam int unsigned PROD_W = 17;   // products of the compare stage

    // Hue windows as bounds on q = floor((60*kp + diff) / (2*diff)), with
    // hue = q - 30 for q >= 30, else q + 150. Upper bounds are exclusive.
    localparam logic [PROD_W-1:0] Q_YEL_LO = PROD_W'(55);
    localparam logic [PROD_W-1:0] Q_YEL_HI = PROD_W'(66);
    localparam logic [PROD_W-1:0] Q_EXP_LO = PROD_W'(60);
    localparam logic [PROD_W-1:0] Q_EXP_HI = PROD_W'(81);
    // red: hue 175..179 gives q 25..29, hue 0..8 gives q 30..38
    localparam logic [PROD_W-1:0] Q_RED_LO = PROD_W'(25);
    localparam logic [PROD_W-1:0] Q_RED_HI = PROD_W'(39);

    // Saturation: s >= T exactly when 510*diff >= (2*T - 1)*max
    localparam logic [PROD_W-1:0] SAT_SCALE  = PROD_W'(510);
    localparam logic [PROD_W-1:0] SAT_YEL_K  = PROD_W'(239);   // s >= 120
    localparam logic [PROD_W-1:0] SAT_RED_K  = PROD_W'(199);   // s >= 100

    localparam logic [CHAN_W-1:0] VAL_YEL_LO = CHAN_W'(150);
    localparam logic [CHAN_W-1:0] VAL_RED_LO = CHAN_W'(100);

    localparam logic [PROD_W-1:0] HUE_SCALE = PROD_W'(60);

    typedef struct packed {
        logic [CHAN_W-1:0] mx;
        logic [CHAN_W-1:0] mn;
        max_sel_t          sel;
        logic signed [CHAN_W:0] dlt;   // channel difference for the hue sector
    } s1_t;

    typedef struct packed {
        logic [CHAN_W-1:0] mx;
        logic [CHAN_W-1:0] diff;
        logic [KP_W-1:0]   kp;
        logic              gray;
    } s2_t;

    typedef struct packed {
        logic [CHAN_W-1:0] mx;
        logic              gray;
        logic [PROD_W-1:0] num;
        logic [PROD_W-1:0] t_yel_lo;
        logic [PROD_W-1:0] t_yel_hi;
        logic [PROD_W-1:0] t_exp_lo;
        logic [PROD_W-1:0] t_exp_hi;
        logic [PROD_W-1:0] t_red_lo;
        logic [PROD_W-1:0] t_red_hi;
        logic [PROD_W-1:0] sat_num;
        logic [PROD_W-1:0] sat_yel;
        logic [PROD_W-1:0] sat_red;
    } s3_t;

endpackage

`default_nettype wire

// ===== sv/hsv_color_threshold_mask.sv =====
// ============================================================================
// hsv_color_threshold_mask
// BGR pixel to HSV color window mask, one pixel per clock when not stalled.
// ============================================================================
// Takes one BGR pixel per transfer and returns one mask bit per pixel, set
// when the pixel's 8-bit HSV value (hue halved to 0..179, rounded) falls in
// the window chosen by color_mode: yellow, experimental yellow or red. The
// block sustains one pixel per clock while m_tready is high. The path from
// input transfer to output valid runs through four register stages (min/max,
// hue numerator, constant products, window compare). Hue and saturation are
// never divided out: each window bound is cross-multiplied by the chroma or
// the max and compared. Each stage holds its data while the stage after it
// is full and stalled, so back pressure on the output fills the pipeline
// before the input stops. Write color_mode only while the pipeline is empty.
// ============================================================================
`default_nettype none

module hsv_color_threshold_mask (
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire logic        cfg_we,
    input  wire logic [1:0]  cfg_wdata,       // color_mode
    input  wire logic        s_tvalid,
    output logic             s_tready,
    input  wire logic [23:0] s_tdata,         // [7:0] blue, [15:8] green, [23:16] red
    output logic             m_tvalid,
    input  wire logic        m_tready,
    output logic [7:0]       m_tdata          // [0] in_color, [7:1] zero
);
    import hsvt_pkg::*;

    logic [1:0] mode_reg;
    logic       v1;
    logic       v2;
    logic       v3;
    logic       v4;
    logic       en1;
    logic       en2;
    logic       en3;
    logic       en4;
    s1_t        d1;
    s2_t        d2;
    s3_t        d3;
    logic       hit;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            mode_reg <= MODE_YELLOW;
        end
        else if (cfg_we)
        begin
            mode_reg <= cfg_wdata;
        end
    end

    // a stage loads when it is empty or its contents move on this cycle
    assign en4 = !v4 || m_tready;
    assign en3 = !v3 || en4;
    assign en2 = !v2 || en3;
    assign en1 = !v1 || en2;

    assign s_tready = en1;

    hsvt_minmax u_minmax (
        .clk       (clk),
        .rst_n     (rst_n),
        .en        (en1),
        .in_valid  (s_tvalid),
        .blue      (s_tdata[7:0]),
        .green     (s_tdata[15:8]),
        .red       (s_tdata[23:16]),
        .out_valid (v1),
        .out_data  (d1)
    );

    hsvt_hue_prep u_hue_prep (
        .clk       (clk),
        .rst_n     (rst_n),
        .en        (en2),
        .in_valid  (v1),
        .in_data   (d1),
        .out_valid (v2),
        .out_data  (d2)
    );

    hsvt_products u_products (
        .clk       (clk),
        .rst_n     (rst_n),
        .en        (en3),
        .in_valid  (v2),
        .in_data   (d2),
        .out_valid (v3),
        .out_data  (d3)
    );

    hsvt_window u_window (
        .clk       (clk),
        .rst_n     (rst_n),
        .en        (en4),
        .in_valid  (v3),
        .in_data   (d3),
        .mode      (mode_reg),
        .out_valid (v4),
        .out_hit   (hit)
    );

    assign m_tvalid = v4;
    assign m_tdata  = {7'd0, hit};

endmodule

`default_nettype wire

// ===== sv/hsvt_minmax.sv =====
// ============================================================================
// hsvt_minmax
// Stage 1: max and min channel, max sector and sector channel difference.
// ============================================================================
`default_nettype none

module hsvt_minmax (
    input  wire logic                   clk,
    input  wire logic                   rst_n,
    input  wire logic                   en,
    input  wire logic                   in_valid,
    input  wire logic [7:0]             blue,
    input  wire logic [7:0]             green,
    input  wire logic [7:0]             red,
    output logic                        out_valid,
    output hsvt_pkg::s1_t               out_data
);
    import hsvt_pkg::*;

    logic valid_reg;
    s1_t  data_reg;
    s1_t  data_next;

    always_comb
    begin
        data_next = '0;
        if (red >= green && red >= blue)
        begin
            data_next.sel = MAX_RED;
            data_next.mx  = red;
            data_next.dlt = $signed({1'b0, green}) - $signed({1'b0, blue});
        end
        else if (green >= blue)
        begin
            data_next.sel = MAX_GREEN;
            data_next.mx  = green;
            data_next.dlt = $signed({1'b0, blue}) - $signed({1'b0, red});
        end
        else
        begin
            data_next.sel = MAX_BLUE;
            data_next.mx  = blue;
            data_next.dlt = $signed({1'b0, red}) - $signed({1'b0, green});
        end

        data_next.mn = blue;
        if (green < data_next.mn)
        begin
            data_next.mn = green;
        end
        if (red < data_next.mn)
        begin
            data_next.mn = red;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else if (en)
        begin
            valid_reg <= in_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            data_reg <= data_next;
        end
    end

    assign out_valid = valid_reg;
    assign out_data  = data_reg;

endmodule

`default_nettype wire

// ===== sv/hsvt_hue_prep.sv =====
// ============================================================================
// hsvt_hue_prep
// Stage 2: chroma (max - min) and non-negative hue numerator kp = k + diff.
// ============================================================================
`default_nettype none

module hsvt_hue_prep (
    input  wire logic                   clk,
    input  wire logic                   rst_n,
    input  wire logic                   en,
    input  wire logic                   in_valid,
    input  wire hsvt_pkg::s1_t          in_data,
    output logic                        out_valid,
    output hsvt_pkg::s2_t               out_data
);
    import hsvt_pkg::*;

    logic                   valid_reg;
    s2_t                    data_reg;
    s2_t                    data_next;
    logic [CHAN_W-1:0]      diff;
    logic signed [KP_W:0]   offs;
    logic signed [KP_W:0]   kp_full;

    assign diff = in_data.mx - in_data.mn;

    // sector offset: 1, 3 or 5 times diff
    always_comb
    begin
        case (in_data.sel)
            MAX_RED:
            begin
                offs = $signed({4'd0, diff});
            end
            MAX_GREEN:
            begin
                offs = $signed({4'd0, diff}) + $signed({3'd0, diff, 1'b0});
            end
            MAX_BLUE:
            begin
                offs = $signed({4'd0, diff}) + $signed({2'd0, diff, 2'b0});
            end
            default:
            begin
                offs = '0;
            end
        endcase
    end

    assign kp_full = offs + {{(KP_W - CHAN_W){in_data.dlt[CHAN_W]}}, in_data.dlt};

    always_comb
    begin
        data_next.mx   = in_data.mx;
        data_next.diff = diff;
        data_next.kp   = kp_full[KP_W-1:0];
        data_next.gray = (diff == '0);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else if (en)
        begin
            valid_reg <= in_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            data_reg <= data_next;
        end
    end

    assign out_valid = valid_reg;
    assign out_data  = data_reg;

endmodule

`default_nettype wire

// ===== sv/hsvt_products.sv =====
// ============================================================================
// hsvt_products
// Stage 3: constant-scaled numerators and window thresholds for hue and
// saturation, so the windows reduce to compares with no divide.
// ============================================================================
`default_nettype none

module hsvt_products (
    input  wire logic                   clk,
    input  wire logic                   rst_n,
    input  wire logic                   en,
    input  wire logic                   in_valid,
    input  wire hsvt_pkg::s2_t          in_data,
    output logic                        out_valid,
    output hsvt_pkg::s3_t               out_data
);
    import hsvt_pkg::*;

    logic              valid_reg;
    s3_t               data_reg;
    s3_t               data_next;
    logic [PROD_W-1:0] diff_x;
    logic [PROD_W-1:0] diff2_x;
    logic [PROD_W-1:0] mx_x;

    assign diff_x  = {{(PROD_W - CHAN_W){1'b0}}, in_data.diff};
    assign diff2_x = {{(PROD_W - CHAN_W - 1){1'b0}}, in_data.diff, 1'b0};
    assign mx_x    = {{(PROD_W - CHAN_W){1'b0}}, in_data.mx};

    always_comb
    begin
        data_next.mx       = in_data.mx;
        data_next.gray     = in_data.gray;
        // rounding term diff folded into the hue numerator
        data_next.num      = {{(PROD_W - KP_W){1'b0}}, in_data.kp} * HUE_SCALE + diff_x;
        data_next.t_yel_lo = diff2_x * Q_YEL_LO;
        data_next.t_yel_hi = diff2_x * Q_YEL_HI;
        data_next.t_exp_lo = diff2_x * Q_EXP_LO;
        data_next.t_exp_hi = diff2_x * Q_EXP_HI;
        data_next.t_red_lo = diff2_x * Q_RED_LO;
        data_next.t_red_hi = diff2_x * Q_RED_HI;
        data_next.sat_num  = diff_x * SAT_SCALE;
        data_next.sat_yel  = mx_x * SAT_YEL_K;
        data_next.sat_red  = mx_x * SAT_RED_K;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else if (en)
        begin
            valid_reg <= in_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            data_reg <= data_next;
        end
    end

    assign out_valid = valid_reg;
    assign out_data  = data_reg;

endmodule

`default_nettype wire

// ===== sv/hsvt_window.sv =====
// ============================================================================
// hsvt_window
// Stage 4: window compares and mode select into the output register.
// ============================================================================
`default_nettype none

module hsvt_window (
    input  wire logic                   clk,
    input  wire logic                   rst_n,
    input  wire logic                   en,
    input  wire logic                   in_valid,
    input  wire hsvt_pkg::s3_t          in_data,
    input  wire logic [1:0]             mode,
    output logic                        out_valid,
    output logic                        out_hit
);
    import hsvt_pkg::*;

    logic valid_reg;
    logic hit_reg;
    logic hit_next;
    logic hue_yel;
    logic hue_exp;
    logic hue_red;
    logic sv_yel;
    logic sv_red;

    // a gray pixel has hue 0, which only the red window covers
    assign hue_yel = !in_data.gray && (in_data.num >= in_data.t_yel_lo)
                     && (in_data.num < in_data.t_yel_hi);
    assign hue_exp = !in_data.gray && (in_data.num >= in_data.t_exp_lo)
                     && (in_data.num < in_data.t_exp_hi);
    assign hue_red = in_data.gray || ((in_data.num >= in_data.t_red_lo)
                     && (in_data.num < in_data.t_red_hi));

    // black fails the value floor, so the saturation compare can ignore it
    assign sv_yel = (in_data.sat_num >= in_data.sat_yel) && (in_data.mx >= VAL_YEL_LO);
    assign sv_red = (in_data.sat_num >= in_data.sat_red) && (in_data.mx >= VAL_RED_LO);

    always_comb
    begin
        case (color_mode_t'(mode))
            MODE_YELLOW:
            begin
                hit_next = hue_yel && sv_yel;
            end
            MODE_YELLOW_EXP:
            begin
                hit_next = hue_exp && sv_yel;
            end
            MODE_RED:
            begin
                hit_next = hue_red && sv_red;
            end
            default:
            begin
                hit_next = 1'b0;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else if (en)
        begin
            valid_reg <= in_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            hit_reg <= hit_next;
        end
    end

    assign out_valid = valid_reg;
    assign out_hit   = hit_reg;

endmodule

`default_nettype wire
